[hdl/gn3_pkg.sv]
// shared constants, types and arithmetic helpers for the gradient noise pipeline
`timescale 1ns / 1ps
package gn3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PERM_SIZE = 256;
    localparam int ADDR_W    = $clog2(PERM_SIZE);
    localparam int ONE_FX    = 1 << FRAC_BITS;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [7:0]          perm_t;
    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [FRAC_BITS:0]  fade_t;
    typedef logic signed [19:0]  lval_t;

    // fixed-point product rounding, magnitude rounded to nearest, ties away from zero
    function automatic logic signed [39:0] fx_round(input logic signed [39:0] p);
        logic [39:0] mag;
        logic [39:0] m;
        begin
            mag = p[39] ? 40'(-p) : 40'(p);
            m   = (mag + 40'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            fx_round = p[39] ? -$signed(m) : $signed(m);
        end
    endfunction

    // a + t * (b - a)
    function automatic lval_t lerp(input fade_t t, input lval_t a, input lval_t b);
        logic signed [20:0] diff;
        logic signed [39:0] p;
        begin
            diff = 21'(b) - 21'(a);
            p    = $signed({23'd0, t}) * 40'(diff);
            lerp = 20'(21'(a) + 21'(fx_round(p)));
        end
    endfunction

    // gradient pick by hash modulo 12, dotted with the corner offset
    function automatic logic signed [18:0] grad_dot(input perm_t h,
                                                    input logic signed [17:0] dx,
                                                    input logic signed [17:0] dy,
                                                    input logic signed [17:0] dz);
        logic [18:0] hq;
        logic [7:0]  q;
        logic [3:0]  r;
        logic signed [18:0] ex;
        logic signed [18:0] ey;
        logic signed [18:0] ez;
        begin
            // h / 12 by reciprocal, exact for 8-bit h
            hq = 19'(h) * 19'd171;
            q  = 8'(hq >> 11);
            r  = 4'(h - 8'(q * 8'd12));
            ex = 19'(dx);
            ey = 19'(dy);
            ez = 19'(dz);
            case (r)
                4'd0:    grad_dot =  ex + ey;
                4'd1:    grad_dot = -ex + ey;
                4'd2:    grad_dot =  ex - ey;
                4'd3:    grad_dot = -ex - ey;
                4'd4:    grad_dot =  ex + ez;
                4'd5:    grad_dot = -ex + ez;
                4'd6:    grad_dot =  ex - ez;
                4'd7:    grad_dot = -ex - ez;
                4'd8:    grad_dot =  ey + ez;
                4'd9:    grad_dot = -ey + ez;
                4'd10:   grad_dot =  ey - ez;
                4'd11:   grad_dot = -ey - ez;
                default: grad_dot = '0;
            endcase
        end
    endfunction

endpackage

[hdl/gradient_noise_3d.sv]
// Gradient noise 3D: one load or evaluate transfer per cycle unless held, via stages
// 1..7 to result register. The permutation table is held in seven identical ram copies
// (two, four and eight corner lookups over three stages); a load transfer writes each copy
// as it passes that copy's stage, so loads and evaluates keep their order. The whole pipe
// advances together and holds while a finished result is stalled; loads give no result.
`timescale 1ns / 1ps
module gradient_noise_3d (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         kind,
    input  logic [7:0]                   table_index,
    input  logic [7:0]                   table_value,
    input  logic [23:0]                  x_pos,
    input  logic [23:0]                  y_pos,
    input  logic [23:0]                  z_pos,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [16:0]                  noise_value
);
    import gn3_pkg::*;

    logic  en, load0, eval0;
    addr_t cx;

    // stage 1
    logic  v1_reg, ld1_reg;
    addr_t idx1_reg, cy1_reg, cz1_reg;
    perm_t val1_reg;
    frac_t fx1_reg, fy1_reg, fz1_reg;
    perm_t l1_a, l1_b;
    addr_t ha, hb;
    // stage 2
    logic  v2_reg, ld2_reg;
    addr_t idx2_reg, cz2_reg;
    perm_t val2_reg;
    frac_t fx2_reg, fy2_reg, fz2_reg;
    perm_t l2a_a, l2a_b, l2b_a, l2b_b;
    addr_t haa, hab, hba, hbb;
    // stage 3
    logic  v3_reg;
    frac_t fx3_reg, fy3_reg, fz3_reg;
    perm_t g000, g001, g010, g011, g100, g101, g110, g111;
    fade_t u3, v3f, w3;
    logic signed [17:0] dx0, dx1, dy0, dy1, dz0, dz1;
    logic signed [18:0] dot_next [8];
    // stage 4..7
    logic  v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [18:0] dot4_reg [8];
    fade_t u4_reg, v4f_reg, w4_reg, v5f_reg, w5_reg, w6_reg;
    lval_t lx5_reg [4];
    lval_t lx5_next [4];
    lval_t lo6_reg, hi6_reg, lo6_next, hi6_next;
    lval_t r7_reg, r7_next;
    // output
    logic        out_valid_reg;
    logic [16:0] noise_reg, noise_next;
    logic signed [20:0] biased;
    logic [17:0] clamped;

    assign en         = !(out_valid_reg && result_stall);
    assign item_stall = !en;
    assign load0      = item_valid && en && (kind == KIND_LOAD);
    assign eval0      = item_valid && en && (kind == KIND_EVAL);
    assign cx         = x_pos[FRAC_BITS +: ADDR_W];

    gn3_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_ram_l1 (
        .clk(clk), .en(en), .we(load0),
        .wr_addr(table_index[ADDR_W-1:0]), .wr_data(table_value),
        .rd_addr_a(cx), .rd_addr_b(cx + addr_t'(1)),
        .rd_data_a(l1_a), .rd_data_b(l1_b)
    );

    gn3_fade u_fade_x (.clk(clk), .en(en), .t(x_pos[FRAC_BITS-1:0]), .fade(u3));
    gn3_fade u_fade_y (.clk(clk), .en(en), .t(y_pos[FRAC_BITS-1:0]), .fade(v3f));
    gn3_fade u_fade_z (.clk(clk), .en(en), .t(z_pos[FRAC_BITS-1:0]), .fade(w3));

    assign ha = l1_a + cy1_reg;
    assign hb = l1_b + cy1_reg;

    gn3_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_ram_l2a (
        .clk(clk), .en(en), .we(en && ld1_reg),
        .wr_addr(idx1_reg), .wr_data(val1_reg),
        .rd_addr_a(ha), .rd_addr_b(ha + addr_t'(1)),
        .rd_data_a(l2a_a), .rd_data_b(l2a_b)
    );
    gn3_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_ram_l2b (
        .clk(clk), .en(en), .we(en && ld1_reg),
        .wr_addr(idx1_reg), .wr_data(val1_reg),
        .rd_addr_a(hb), .rd_addr_b(hb + addr_t'(1)),
        .rd_data_a(l2b_a), .rd_data_b(l2b_b)
    );

    assign haa = l2a_a + cz2_reg;
    assign hab = l2a_b + cz2_reg;
    assign hba = l2b_a + cz2_reg;
    assign hbb = l2b_b + cz2_reg;

    gn3_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_ram_aa (
        .clk(clk), .en(en), .we(en && ld2_reg),
        .wr_addr(idx2_reg), .wr_data(val2_reg),
        .rd_addr_a(haa), .rd_addr_b(haa + addr_t'(1)),
        .rd_data_a(g000), .rd_data_b(g001)
    );
    gn3_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_ram_ab (
        .clk(clk), .en(en), .we(en && ld2_reg),
        .wr_addr(idx2_reg), .wr_data(val2_reg),
        .rd_addr_a(hab), .rd_addr_b(hab + addr_t'(1)),
        .rd_data_a(g010), .rd_data_b(g011)
    );
    gn3_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_ram_ba (
        .clk(clk), .en(en), .we(en && ld2_reg),
        .wr_addr(idx2_reg), .wr_data(val2_reg),
        .rd_addr_a(hba), .rd_addr_b(hba + addr_t'(1)),
        .rd_data_a(g100), .rd_data_b(g101)
    );
    gn3_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_ram_bb (
        .clk(clk), .en(en), .we(en && ld2_reg),
        .wr_addr(idx2_reg), .wr_data(val2_reg),
        .rd_addr_a(hbb), .rd_addr_b(hbb + addr_t'(1)),
        .rd_data_a(g110), .rd_data_b(g111)
    );

    // corner offsets: near corner is the fraction, far corner is fraction minus one
    always_comb
    begin
        dx0 = 18'(fx3_reg);
        dy0 = 18'(fy3_reg);
        dz0 = 18'(fz3_reg);
        dx1 = dx0 - 18'(ONE_FX);
        dy1 = dy0 - 18'(ONE_FX);
        dz1 = dz0 - 18'(ONE_FX);
        dot_next[0] = grad_dot(g000, dx0, dy0, dz0);
        dot_next[1] = grad_dot(g100, dx1, dy0, dz0);
        dot_next[2] = grad_dot(g010, dx0, dy1, dz0);
        dot_next[3] = grad_dot(g110, dx1, dy1, dz0);
        dot_next[4] = grad_dot(g001, dx0, dy0, dz1);
        dot_next[5] = grad_dot(g101, dx1, dy0, dz1);
        dot_next[6] = grad_dot(g011, dx0, dy1, dz1);
        dot_next[7] = grad_dot(g111, dx1, dy1, dz1);
    end

    always_comb
    begin
        lx5_next[0] = lerp(u4_reg, 20'(dot4_reg[0]), 20'(dot4_reg[1]));
        lx5_next[1] = lerp(u4_reg, 20'(dot4_reg[2]), 20'(dot4_reg[3]));
        lx5_next[2] = lerp(u4_reg, 20'(dot4_reg[4]), 20'(dot4_reg[5]));
        lx5_next[3] = lerp(u4_reg, 20'(dot4_reg[6]), 20'(dot4_reg[7]));
        lo6_next    = lerp(v5f_reg, lx5_reg[0], lx5_reg[1]);
        hi6_next    = lerp(v5f_reg, lx5_reg[2], lx5_reg[3]);
        r7_next     = lerp(w6_reg, lo6_reg, hi6_reg);
    end

    // (res + 1) / 2 with clamp, rounding half up
    always_comb
    begin
        biased = 21'(r7_reg) + 21'(ONE_FX);
        if (biased < 0)
        begin
            clamped = '0;
        end
        else if (biased > 21'(2 * ONE_FX))
        begin
            clamped = 18'(2 * ONE_FX);
        end
        else
        begin
            clamped = 18'(biased);
        end
        noise_next = 17'((19'(clamped) + 19'd1) >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            ld1_reg       <= 1'b0;
            v2_reg        <= 1'b0;
            ld2_reg       <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= eval0;
            ld1_reg       <= load0;
            v2_reg        <= v1_reg;
            ld2_reg       <= ld1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            out_valid_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg  <= table_index[ADDR_W-1:0];
            val1_reg  <= table_value;
            cy1_reg   <= y_pos[FRAC_BITS +: ADDR_W];
            cz1_reg   <= z_pos[FRAC_BITS +: ADDR_W];
            fx1_reg   <= x_pos[FRAC_BITS-1:0];
            fy1_reg   <= y_pos[FRAC_BITS-1:0];
            fz1_reg   <= z_pos[FRAC_BITS-1:0];
            idx2_reg  <= idx1_reg;
            val2_reg  <= val1_reg;
            cz2_reg   <= cz1_reg;
            fx2_reg   <= fx1_reg;
            fy2_reg   <= fy1_reg;
            fz2_reg   <= fz1_reg;
            fx3_reg   <= fx2_reg;
            fy3_reg   <= fy2_reg;
            fz3_reg   <= fz2_reg;
            dot4_reg  <= dot_next;
            u4_reg    <= u3;
            v4f_reg   <= v3f;
            w4_reg    <= w3;
            lx5_reg   <= lx5_next;
            v5f_reg   <= v4f_reg;
            w5_reg    <= w4_reg;
            lo6_reg   <= lo6_next;
            hi6_reg   <= hi6_next;
            w6_reg    <= w5_reg;
            r7_reg    <= r7_next;
            noise_reg <= noise_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign noise_value  = noise_reg;

    // last stage moving forward always presents a result
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && v7_reg |=> result_valid)
        else $error("evaluate lost between last stage and output");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> noise_value <= 17'd65536)
        else $error("noise value above one");

    // input is held back only by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a stalled result");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v7_reg) && $stable(v4_reg) && $stable(ld1_reg))
        else $error("pipeline moved while held");
endmodule

[hdl/gn3_ram.sv]
// generic one-write two-read ram with registered read data
`timescale 1ns / 1ps
module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end
endmodule

[hdl/gn3_fade.sv]
// three-stage quintic fade 6t^5 - 15t^4 + 10t^3
`timescale 1ns / 1ps
module gn3_fade (
    input  logic           clk,
    input  logic           en,
    input  gn3_pkg::frac_t t,
    output gn3_pkg::fade_t fade
);
    import gn3_pkg::*;

    frac_t              t1_reg;
    logic [16:0]        sq1_reg, sq1_next;
    logic signed [21:0] in1_reg, in1_next;
    logic [16:0]        cube2_reg, cube2_next;
    logic [20:0]        inner2_reg, inner2_next;
    fade_t              fade3_reg, fade3_next;

    logic signed [21:0] lin;
    logic signed [39:0] p_sq, p_in, p_cu, p_f;

    always_comb
    begin
        lin         = 22'($signed({6'd0, t}) * 22'sd6) - 22'(15 * ONE_FX);
        p_sq        = $signed({24'd0, t}) * $signed({24'd0, t});
        p_in        = $signed({24'd0, t}) * 40'(lin);
        sq1_next    = 17'(fx_round(p_sq));
        in1_next    = 22'(fx_round(p_in));
        p_cu        = $signed({23'd0, sq1_reg}) * $signed({24'd0, t1_reg});
        cube2_next  = 17'(fx_round(p_cu));
        inner2_next = 21'(in1_reg + 22'(10 * ONE_FX));
        p_f         = $signed({23'd0, cube2_reg}) * $signed({19'd0, inner2_reg});
        fade3_next  = 17'(fx_round(p_f));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg     <= t;
            sq1_reg    <= sq1_next;
            in1_reg    <= in1_next;
            cube2_reg  <= cube2_next;
            inner2_reg <= inner2_next;
            fade3_reg  <= fade3_next;
        end
    end

    assign fade = fade3_reg;
endmodule
